// ===== rtl/serial_rgb_led_pulse_encoder_macros.svh =====
// Assertion macros used by the serial RGB LED pulse encoder checker.
// Expects aclk and aresetn to be visible at the point of use.
`ifndef SERIAL_RGB_LED_PULSE_ENCODER_MACROS_SVH
`define SERIAL_RGB_LED_PULSE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srle assertion failed");

// Next-cycle implication, disabled during reset
`define SRLE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srle assertion failed");

`endif

// ===== rtl/srle_pkg.sv =====
// Package for the serial RGB LED pulse encoder: opcodes, register indexes,
// phase encoding and the structs passed between modules. No dependencies.
`default_nettype none

package srle_pkg;

    // Command opcodes carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_LATCH = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_LOW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATCH_LOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] RST_ZERO_HIGH   = 16'd6;
    localparam logic [15:0] RST_ZERO_LOW    = 16'd32;
    localparam logic [15:0] RST_ONE_HIGH    = 16'd22;
    localparam logic [15:0] RST_ONE_LOW     = 16'd12;
    localparam logic [15:0] RST_LATCH_LOW   = 16'd5760;
    localparam logic [7:0]  RST_PIXEL_COUNT = 8'd60;

    // 24 bits per pixel, sent green, red, blue, MSB first
    localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

    // Line phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_LATCH = 4'b1000
    } srle_phase_t;

    typedef struct packed {
        logic [15:0] zero_high_ticks;
        logic [15:0] zero_low_ticks;
        logic [15:0] one_high_ticks;
        logic [15:0] one_low_ticks;
        logic [15:0] latch_low_ticks;
        logic [7:0]  pixel_count;
    } srle_cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } srle_item_t;

    typedef struct packed {
        logic refused;
        logic busy_res;
        logic line_level;
    } srle_result_t;

endpackage

`default_nettype wire

// ===== rtl/srle_cfg_regs.sv =====
// Configuration register file of the serial RGB LED pulse encoder.
// Depends on srle_pkg for register indexes, reset values and srle_cfg_t.
`default_nettype none

module srle_cfg_regs import srle_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output srle_cfg_t                   cfg
);

    srle_cfg_t cfg_reg;

    // Writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_ticks <= RST_ZERO_HIGH;
            cfg_reg.zero_low_ticks  <= RST_ZERO_LOW;
            cfg_reg.one_high_ticks  <= RST_ONE_HIGH;
            cfg_reg.one_low_ticks   <= RST_ONE_LOW;
            cfg_reg.latch_low_ticks <= RST_LATCH_LOW;
            cfg_reg.pixel_count     <= RST_PIXEL_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ZERO_HIGH:   cfg_reg.zero_high_ticks <= cfg_data;
                CFG_ZERO_LOW:    cfg_reg.zero_low_ticks  <= cfg_data;
                CFG_ONE_HIGH:    cfg_reg.one_high_ticks  <= cfg_data;
                CFG_ONE_LOW:     cfg_reg.one_low_ticks   <= cfg_data;
                CFG_LATCH_LOW:   cfg_reg.latch_low_ticks <= cfg_data;
                CFG_PIXEL_COUNT: cfg_reg.pixel_count     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srle_core.sv =====
// Pulse engine of the serial RGB LED pulse encoder: line phase, bit shifter,
// tick and pixel counters. Depends on srle_pkg.
`default_nettype none

module srle_core import srle_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire srle_item_t  item,
    input  wire srle_cfg_t   cfg,
    output srle_result_t     res
);

    localparam int TW = TICK_COUNT_WIDTH;

    srle_phase_t   phase_reg, phase_next, cmd_phase;
    logic [TW-1:0] ticks_reg, ticks_next, cmd_ticks;
    logic [23:0]   held_reg, held_next;
    logic [23:0]   shift_reg, shift_next, cmd_shift, shift_adv, new_colour;
    logic [4:0]    bits_reg, bits_next, cmd_bits, bits_adv;
    logic [7:0]    pix_reg, pix_next, cmd_pix;
    logic          idle_level_reg, idle_level_next;
    logic          refused;
    logic          level;

    // Duration from a 16-bit register: low TW bits, zero counts as one tick
    function automatic logic [TW-1:0] dur(input logic [15:0] r);
        logic [TW-1:0] v;
        v = TW'(r);
        return (v == '0) ? TW'(1) : v;
    endfunction

    function automatic logic [TW-1:0] high_dur(input logic b, input srle_cfg_t c);
        return b ? dur(c.one_high_ticks) : dur(c.zero_high_ticks);
    endfunction

    function automatic logic [TW-1:0] low_dur(input logic b, input srle_cfg_t c);
        return b ? dur(c.one_low_ticks) : dur(c.zero_low_ticks);
    endfunction

    assign new_colour = {item.green, item.red, item.blue};

    // Command decode: an accepted command starts in this very tick
    always_comb begin
        cmd_phase = phase_reg;
        cmd_ticks = ticks_reg;
        cmd_shift = shift_reg;
        cmd_bits  = bits_reg;
        cmd_pix   = pix_reg;
        held_next = held_reg;
        refused   = 1'b0;
        if (item.opcode != OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                refused = 1'b1;
            end else if (item.opcode == OP_LATCH) begin
                cmd_phase = PH_LATCH;
                cmd_ticks = dur(cfg.latch_low_ticks);
            end else begin
                held_next = new_colour;
                cmd_pix   = (item.opcode == OP_FILL && cfg.pixel_count > 8'd1) ?
                            cfg.pixel_count - 8'd1 : 8'd0;
                cmd_shift = new_colour;
                cmd_bits  = BITS_PER_PIXEL;
                cmd_phase = PH_HIGH;
                cmd_ticks = high_dur(new_colour[23], cfg);
            end
        end
    end

    // Line level seen during this tick
    assign level = (cmd_phase == PH_IDLE) ? idle_level_reg : (cmd_phase == PH_HIGH);

    assign shift_adv = {cmd_shift[22:0], 1'b0};
    assign bits_adv  = cmd_bits - 5'd1;

    // Advance by one tick
    always_comb begin
        phase_next      = cmd_phase;
        ticks_next      = cmd_ticks - TW'(1);
        shift_next      = cmd_shift;
        bits_next       = cmd_bits;
        pix_next        = cmd_pix;
        idle_level_next = idle_level_reg;
        unique case (cmd_phase)
            PH_IDLE: begin
                ticks_next = cmd_ticks;
            end
            PH_HIGH: begin
                if (cmd_ticks == TW'(1)) begin
                    phase_next = PH_LOW;
                    ticks_next = low_dur(cmd_shift[23], cfg);
                end
            end
            PH_LOW: begin
                if (cmd_ticks == TW'(1)) begin
                    shift_next = shift_adv;
                    bits_next  = bits_adv;
                    if (bits_adv != 5'd0) begin
                        phase_next = PH_HIGH;
                        ticks_next = high_dur(shift_adv[23], cfg);
                    end else if (cmd_pix != 8'd0) begin
                        pix_next   = cmd_pix - 8'd1;
                        shift_next = held_next;
                        bits_next  = BITS_PER_PIXEL;
                        phase_next = PH_HIGH;
                        ticks_next = high_dur(held_next[23], cfg);
                    end else begin
                        phase_next      = PH_IDLE;
                        idle_level_next = 1'b0;
                    end
                end
            end
            PH_LATCH: begin
                if (cmd_ticks == TW'(1)) begin
                    phase_next      = PH_IDLE;
                    idle_level_next = 1'b0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                ticks_next = cmd_ticks;
            end
        endcase
    end

    assign res.line_level = level;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.refused    = refused;

    // State registers, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            ticks_reg      <= '0;
            held_reg       <= '0;
            shift_reg      <= '0;
            bits_reg       <= '0;
            pix_reg        <= '0;
            idle_level_reg <= 1'b1;
        end else if (step) begin
            phase_reg      <= phase_next;
            ticks_reg      <= ticks_next;
            held_reg       <= held_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            pix_reg        <= pix_next;
            idle_level_reg <= idle_level_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/serial_rgb_led_pulse_encoder.sv =====
// Serial RGB LED pulse encoder for a one-wire addressable LED line, top level.
// Uses srle_pkg, srle_cfg_regs and srle_core.
//
// Every input transaction is one tick of line time and yields exactly one
// result transaction with the line level for that tick, a busy flag and a
// refused flag. The block takes one transaction per clock, sustained, when
// the output is not stalled; a result is offered once its input has passed
// the input register and then the result register, and the combinational
// path between them through the phase, tick counter and bit shifter update
// sets the clock rate. Opcodes in s_tuser: tick, send one
// pixel, fill pixel_count pixels, latch reset. Commands arriving while busy
// are dropped and flagged. Bits go out green, red, blue, MSB first.
// Configuration writes belong in idle periods only.
`default_nettype none

module serial_rgb_led_pulse_encoder import srle_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic [1:0]             s_tuser,   // opcode[1:0]
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // line_level[0], busy_res[1], refused[2]
    // Configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    srle_cfg_t    cfg;
    srle_item_t   item_reg;
    srle_result_t res;
    srle_result_t res_reg;
    logic         in_valid_reg;
    logic         m_valid_reg;
    logic         step;

    srle_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Registered item moves on when the result slot is free or draining
    assign step     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode <= s_tuser;
            item_reg.red    <= s_tdata[7:0];
            item_reg.green  <= s_tdata[15:8];
            item_reg.blue   <= s_tdata[23:16];
        end
    end

    srle_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, res_reg.refused, res_reg.busy_res, res_reg.line_level};

endmodule

`default_nettype wire

// ===== rtl/srle_checker.sv =====
// Port-level checker for the serial RGB LED pulse encoder, bound to the top.
// Depends on serial_rgb_led_pulse_encoder_macros.svh.
`default_nettype none

`include "serial_rgb_led_pulse_encoder_macros.svh"

module srle_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] in_flight_reg;
    logic       last_busy_reg;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Items taken but not yet answered, and busy flag of the last result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= 2'd0;
            last_busy_reg <= 1'b0;
        end else begin
            in_flight_reg <= in_flight_reg + 2'(s_acc) - 2'(m_acc);
            if (m_acc) begin
                last_busy_reg <= m_tdata[1];
            end
        end
    end

    // Handshake: a stalled result holds
    `SRLE_ASSERT_NXT(a_m_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `SRLE_ASSERT_NXT(a_m_data_holds, m_tvalid && !m_tready, $stable(m_tdata))
    // No result without a matching input, and at most two items inside
    `SRLE_ASSERT_IMP(a_no_extra_result, m_acc, in_flight_reg != 2'd0)
    `SRLE_ASSERT_IMP(a_depth, 1'b1, in_flight_reg != 2'd3)
    // A refusal only follows a result that reported busy
    `SRLE_ASSERT_IMP(a_refused_when_busy, m_acc && m_tdata[2], last_busy_reg)

endmodule

bind serial_rgb_led_pulse_encoder srle_checker u_srle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
